### sv/stl_pkg.sv
// ----------------------------------------------------------------------------
// stl_pkg
// Shared constants, types and saturating helpers for the sync timing learner.
// ----------------------------------------------------------------------------
package stl_pkg;

    // Internal counter widths.
    localparam int CLOCK_BITS = 20;
    localparam int LINE_BITS  = 16;

    // Fixed widths of the stream fields.
    localparam int RUN_BITS   = 16;
    localparam int OUT_CLK_W  = 20;
    localparam int OUT_LINE_W = 16;
    localparam int GLITCH_W   = 16;
    localparam int REJ_W      = 8;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 112;
    localparam int OUT_USER_W = 2;

    localparam logic [REJ_W-1:0] GIVE_UP_RESET = 8'd16;

    // Sum wide enough for a clock count plus a run length without wrap.
    localparam int SUM_BITS = ((CLOCK_BITS > RUN_BITS) ? CLOCK_BITS : RUN_BITS) + 1;

    localparam logic [CLOCK_BITS-1:0] CMAX = '1;
    localparam logic [LINE_BITS-1:0]  LMAX = '1;
    localparam logic [REJ_W-1:0]      RMAX = '1;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_LINE  = 2'd1,
        EV_FRAME = 2'd2,
        EV_RETRO = 2'd3
    } t_event;

    function automatic logic [CLOCK_BITS-1:0] sat_clk(
        input logic [CLOCK_BITS-1:0] a,
        input logic [SUM_BITS-2:0]   b
    );
        logic [SUM_BITS-1:0] s;
        s = SUM_BITS'(a) + SUM_BITS'(b);
        return (s > SUM_BITS'(CMAX)) ? CMAX : s[CLOCK_BITS-1:0];
    endfunction

    function automatic logic [LINE_BITS-1:0] inc_line(input logic [LINE_BITS-1:0] a);
        return (a == LMAX) ? a : a + 1'b1;
    endfunction

endpackage

### sv/sync_timing_learner.sv
// ----------------------------------------------------------------------------
// sync_timing_learner
// Learns hsync/vsync polarity, widths, line period and frame length from
// run-length coded sync samples, with glitch rejection and lock detection.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one run per beat: {run_clocks, v_level, h_level} in tdata.
//   m_axis returns one result per run: the event code in tuser and the
//   current learned timing in tdata.
//   i_cfg_we/i_cfg_wdata write the give-up count; write it only while idle.
// Path: a run accepted from s_axis passes through the input register, then
//   the result register, before its result is on m_axis.
// Throughput: one run per clock while m_axis is not held off. All learning is
//   a single pass of logic between the input register and the result
//   register, so the recurrence closes within that pass.
// Stall: when m_axis is held off, the result register holds; one more run is
//   taken into the input register if it is empty, after which s_axis_tready drops.
// Reset: synchronous, active low. Clears all learned state, both pipeline
//   valids, and loads a give-up count of 16.
// ----------------------------------------------------------------------------
module sync_timing_learner
    import stl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // Bits from 0: h_level, v_level, run_clocks[15:0], zero pad.
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // Bits from 0: h_pol, h_width[19:0], line_period[19:0],
    // v_pol, v_pulse_lines[15:0], frame_lines[15:0], locked,
    // glitches[15:0], report_pos[19:0], zero pad.
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // Bits from 0: event_res[1:0].
    output logic [OUT_USER_W-1:0] m_axis_tuser,
    input  logic                  i_cfg_we,
    input  logic [REJ_W-1:0]      i_cfg_wdata
);

    // Pipeline control.
    logic                  r_in_valid;
    logic                  r_in_h;
    logic                  r_in_v;
    logic [RUN_BITS-1:0]   r_in_run;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    t_event                r_out_event;
    logic                  adv;
    logic                  step;

    logic [REJ_W-1:0]      r_give_up;

    // Learned state.
    logic                  r_started, n_started;
    logic                  r_prev_h, n_prev_h;
    logic                  r_prev_v, n_prev_v;
    logic [CLOCK_BITS-1:0] r_h_high, n_h_high;
    logic [CLOCK_BITS-1:0] r_h_low, n_h_low;
    logic [CLOCK_BITS-1:0] r_clock_in_line, n_clock_in_line;
    logic                  r_pulse_live, n_pulse_live;
    logic [CLOCK_BITS-1:0] r_pulse_start, n_pulse_start;
    logic [REJ_W-1:0]      r_rejected, n_rejected;
    logic                  r_h_pol, n_h_pol;
    logic [CLOCK_BITS-1:0] r_h_width, n_h_width;
    logic [CLOCK_BITS-1:0] r_line_period, n_line_period;
    logic [LINE_BITS-1:0]  r_v_high, n_v_high;
    logic [LINE_BITS-1:0]  r_v_low, n_v_low;
    logic                  r_v_seen, n_v_seen;
    logic [LINE_BITS-1:0]  r_line_in_frame, n_line_in_frame;
    logic [LINE_BITS-1:0]  r_prev_frame_lines, n_prev_frame_lines;
    logic [CLOCK_BITS-1:0] r_prev_line_period, n_prev_line_period;
    logic                  r_v_pol, n_v_pol;
    logic [LINE_BITS-1:0]  r_v_pulse_lines, n_v_pulse_lines;
    logic [LINE_BITS-1:0]  r_frame_lines, n_frame_lines;
    logic                  r_lock, n_lock;
    logic [GLITCH_W-1:0]   r_glitches, n_glitches;
    logic [CLOCK_BITS-1:0] r_report_pos, n_report_pos;
    t_event                n_event;

    assign adv           = !r_out_valid || m_axis_tready;
    assign step          = adv && r_in_valid;
    assign s_axis_tready = adv || !r_in_valid;

    always_comb begin
        logic                  h;
        logic                  v;
        logic [CLOCK_BITS-1:0] done;
        logic [CLOCK_BITS-1:0] other;
        logic                  lvl;
        logic                  know;
        logic                  dropped;
        logic [CLOCK_BITS-1:0] slack;
        logic                  width_ok;
        logic [LINE_BITS-1:0]  v_done;
        logic [LINE_BITS-1:0]  v_other;
        logic                  v_lvl;
        logic [LINE_BITS-1:0]  v_len;
        logic                  first;

        h       = r_in_h;
        v       = r_in_v;
        done    = '0;
        other   = '0;
        lvl     = 1'b0;
        know    = 1'b0;
        dropped = 1'b0;
        slack   = '0;
        width_ok = 1'b0;
        v_done  = '0;
        v_other = '0;
        v_lvl   = 1'b0;
        v_len   = '0;
        first   = 1'b0;

        n_started          = r_started;
        n_prev_h           = r_prev_h;
        n_prev_v           = r_prev_v;
        n_h_high           = r_h_high;
        n_h_low            = r_h_low;
        n_clock_in_line    = r_clock_in_line;
        n_pulse_live       = r_pulse_live;
        n_pulse_start      = r_pulse_start;
        n_rejected         = r_rejected;
        n_h_pol            = r_h_pol;
        n_h_width          = r_h_width;
        n_line_period      = r_line_period;
        n_v_high           = r_v_high;
        n_v_low            = r_v_low;
        n_v_seen           = r_v_seen;
        n_line_in_frame    = r_line_in_frame;
        n_prev_frame_lines = r_prev_frame_lines;
        n_prev_line_period = r_prev_line_period;
        n_v_pol            = r_v_pol;
        n_v_pulse_lines    = r_v_pulse_lines;
        n_frame_lines      = r_frame_lines;
        n_lock             = r_lock;
        n_glitches         = r_glitches;
        n_report_pos       = r_report_pos;
        n_event            = EV_NONE;

        if (!r_started) begin
            n_started = 1'b1;
            n_prev_h  = h;
            n_prev_v  = v;
            if (v) begin
                n_v_high = LINE_BITS'(1);
            end else begin
                n_v_low = LINE_BITS'(1);
            end
        end

        if (h != n_prev_h) begin
            done  = n_prev_h ? n_h_high : n_h_low;
            other = n_prev_h ? n_h_low : n_h_high;
            if (n_h_width != '0 && n_line_period != '0) begin
                lvl  = n_h_pol;
                know = 1'b1;
            end else if (other != '0) begin
                // Before the timing is known, the shorter phase is the pulse.
                if (done < other) begin
                    lvl       = n_prev_h;
                    n_h_width = done;
                end else begin
                    lvl       = h;
                    n_h_width = other;
                end
                n_h_pol = lvl;
                know    = 1'b1;
            end

            slack    = n_h_width >> 2;
            width_ok = ({1'b0, done} + {1'b0, slack} >= {1'b0, n_h_width})
                    && ({1'b0, done} <= {1'b0, n_h_width} + {1'b0, slack})
                    && (n_pulse_start >= (n_line_period >> 1));

            if (know && h == lvl) begin
                n_pulse_live  = 1'b1;
                n_pulse_start = n_clock_in_line;
            end else if (know && n_pulse_live) begin
                n_pulse_live = 1'b0;
                if (n_rejected >= r_give_up) begin
                    n_h_width       = '0;
                    n_line_period   = '0;
                    n_clock_in_line = '0;
                    n_h_high        = '0;
                    n_h_low         = '0;
                    n_rejected      = '0;
                    n_glitches      = n_glitches + 1'b1;
                end else if (!(n_h_width != '0 && n_line_period != '0) || width_ok) begin
                    n_h_pol   = lvl;
                    n_h_width = done;
                    if (n_pulse_start != '0) begin
                        n_line_period = n_pulse_start;
                    end
                    n_clock_in_line = done;
                    n_report_pos    = done;
                    n_rejected      = '0;
                    n_line_in_frame = inc_line(n_line_in_frame);
                    n_event         = EV_LINE;

                    // Vsync is sampled once per accepted line start.
                    if (v != n_prev_v) begin
                        v_done  = n_prev_v ? n_v_high : n_v_low;
                        v_other = n_prev_v ? n_v_low : n_v_high;
                        if (v_other != '0) begin
                            if (v_done < v_other) begin
                                v_lvl = n_prev_v;
                                v_len = v_done;
                            end else begin
                                v_lvl = v;
                                v_len = v_other;
                            end
                            n_v_pol         = v_lvl;
                            n_v_pulse_lines = v_len;
                            first           = !n_v_seen;
                            n_v_seen        = 1'b1;
                            if (v == v_lvl) begin
                                n_frame_lines = n_line_in_frame;
                                n_lock = (n_prev_frame_lines != '0)
                                      && (n_frame_lines == n_prev_frame_lines)
                                      && (n_line_period == n_prev_line_period);
                                n_prev_frame_lines = n_frame_lines;
                                n_prev_line_period = n_line_period;
                                n_line_in_frame    = '0;
                                n_event            = EV_FRAME;
                            end else begin
                                // Entering the blank phase first: the frame
                                // began this many lines ago.
                                n_line_in_frame = v_len;
                                if (first) begin
                                    n_event = EV_RETRO;
                                end
                            end
                        end
                        if (v) begin
                            n_v_high = '0;
                        end else begin
                            n_v_low = '0;
                        end
                    end
                    if (v) begin
                        n_v_high = inc_line(n_v_high);
                    end else begin
                        n_v_low = inc_line(n_v_low);
                    end
                    n_prev_v = v;
                end else begin
                    n_glitches = n_glitches + 1'b1;
                    n_rejected = (n_rejected == RMAX) ? n_rejected : n_rejected + 1'b1;
                    dropped    = 1'b1;
                end
            end

            // A rejected pulse is folded back into the phase it interrupted.
            if (dropped) begin
                if (h) begin
                    n_h_high = sat_clk(n_h_high, (SUM_BITS-1)'(done));
                end else begin
                    n_h_low = sat_clk(n_h_low, (SUM_BITS-1)'(done));
                end
            end else begin
                if (h) begin
                    n_h_high = '0;
                end else begin
                    n_h_low = '0;
                end
            end
            n_prev_h = h;
        end

        if (h) begin
            n_h_high = sat_clk(n_h_high, (SUM_BITS-1)'(r_in_run));
        end else begin
            n_h_low = sat_clk(n_h_low, (SUM_BITS-1)'(r_in_run));
        end
        n_clock_in_line = sat_clk(n_clock_in_line, (SUM_BITS-1)'(r_in_run));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_give_up   <= GIVE_UP_RESET;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
            if (i_cfg_we) begin
                r_give_up <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_h   <= s_axis_tdata[0];
            r_in_v   <= s_axis_tdata[1];
            r_in_run <= s_axis_tdata[RUN_BITS+1:2];
        end
        if (step) begin
            r_out_event <= n_event;
            r_out_data  <= {1'b0,
                            OUT_CLK_W'(n_report_pos),
                            n_glitches,
                            n_lock,
                            OUT_LINE_W'(n_frame_lines),
                            OUT_LINE_W'(n_v_pulse_lines),
                            n_v_pol,
                            OUT_CLK_W'(n_line_period),
                            OUT_CLK_W'(n_h_width),
                            n_h_pol};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started          <= 1'b0;
            r_prev_h           <= 1'b0;
            r_prev_v           <= 1'b0;
            r_h_high           <= '0;
            r_h_low            <= '0;
            r_clock_in_line    <= '0;
            r_pulse_live       <= 1'b0;
            r_pulse_start      <= '0;
            r_rejected         <= '0;
            r_h_pol            <= 1'b0;
            r_h_width          <= '0;
            r_line_period      <= '0;
            r_v_high           <= '0;
            r_v_low            <= '0;
            r_v_seen           <= 1'b0;
            r_line_in_frame    <= '0;
            r_prev_frame_lines <= '0;
            r_prev_line_period <= '0;
            r_v_pol            <= 1'b0;
            r_v_pulse_lines    <= '0;
            r_frame_lines      <= '0;
            r_lock             <= 1'b0;
            r_glitches         <= '0;
            r_report_pos       <= '0;
        end else if (step) begin
            r_started          <= n_started;
            r_prev_h           <= n_prev_h;
            r_prev_v           <= n_prev_v;
            r_h_high           <= n_h_high;
            r_h_low            <= n_h_low;
            r_clock_in_line    <= n_clock_in_line;
            r_pulse_live       <= n_pulse_live;
            r_pulse_start      <= n_pulse_start;
            r_rejected         <= n_rejected;
            r_h_pol            <= n_h_pol;
            r_h_width          <= n_h_width;
            r_line_period      <= n_line_period;
            r_v_high           <= n_v_high;
            r_v_low            <= n_v_low;
            r_v_seen           <= n_v_seen;
            r_line_in_frame    <= n_line_in_frame;
            r_prev_frame_lines <= n_prev_frame_lines;
            r_prev_line_period <= n_prev_line_period;
            r_v_pol            <= n_v_pol;
            r_v_pulse_lines    <= n_v_pulse_lines;
            r_frame_lines      <= n_frame_lines;
            r_lock             <= n_lock;
            r_glitches         <= n_glitches;
            r_report_pos       <= n_report_pos;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_event;

    // Learned state moves only when a run passes into the result register.
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !step |=> $stable(r_glitches) && $stable(r_clock_in_line) && $stable(r_started))
        else $error("learned state changed without a run stepping");

    // Any reported event comes from an accepted line, which clears the rejection run.
    a_event_clears_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && n_event != EV_NONE |=> r_rejected == '0)
        else $error("event reported while rejections remain");

    // At most one glitch is counted per run.
    a_glitch_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_glitches == $past(r_glitches))
              || (r_glitches == $past(r_glitches) + 1'b1))
        else $error("glitch counter jumped");

    // Input side only stalls with both pipeline registers occupied.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_in_valid && r_out_valid)
        else $error("input stalled with a free pipeline slot");

    // A frame event can only follow the first vsync pulse being seen.
    a_frame_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && (n_event == EV_FRAME || n_event == EV_RETRO) |=> r_v_seen)
        else $error("frame event before any vsync pulse");

endmodule
